// ===== rtl/fpa_pkg.sv =====
// Shared definitions of the fixed-point ALU: operation codes and defaults.
// No dependencies; imported by the interfaces and all RTL modules.
package fpa_pkg;

  // Default number of fractional bits of the Q format
  localparam int FRAC_BITS_DEF = 8;

  // Operation codes carried in the func field of an item
  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_GT       = 4'd4,
    FN_LT       = 4'd5,
    FN_GE       = 4'd6,
    FN_LE       = 4'd7,
    FN_EQ       = 4'd8,
    FN_NE       = 4'd9,
    FN_MIN      = 4'd10,
    FN_MAX      = 4'd11,
    FN_INC      = 4'd12,
    FN_DEC      = 4'd13,
    FN_FROM_INT = 4'd14,
    FN_TO_INT   = 4'd15
  } func_e;

endpackage

// ===== rtl/fpa_req_if.sv =====
// Request channel of the fixed-point ALU: valid/ready plus opcode and operands.
// Depends on fpa_pkg for the opcode type.
interface fpa_req_if import fpa_pkg::*; ();
  logic               valid;
  logic               ready;
  func_e              func;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

// ===== rtl/fpa_rsp_if.sv =====
// Result channel of the fixed-point ALU: valid/ready plus result and flags.
// Depends on fpa_pkg only by convention of the project.
interface fpa_rsp_if import fpa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               compare_true;
  logic               divide_by_zero;

  modport source (output valid, result, compare_true, divide_by_zero, input ready);
  modport sink   (input valid, result, compare_true, divide_by_zero, output ready);
endinterface

// ===== rtl/fixed_point_alu_core.sv =====
// Signed 32-bit fixed-point ALU, FRAC_BITS fractional bits.
// Depends on fpa_pkg, fpa_req_if, fpa_rsp_if and fpa_div_step.
//
// Usage:
//   in_req  : items of opcode, operand_a, operand_b (valid/ready).
//   out_rsp : one item per request: result, compare_true, divide_by_zero.
//   Items leave in the order they entered.
// Path: the input register loads at the accepting edge; after it come an
//   operand stage with the 32x32 multiplier, FRAC_BITS + 32 restoring
//   divider steps of one quotient bit each, and the result select stage
//   that drives out_rsp. Every operation travels the same path.
// Throughput: one item per cycle without a stall; every stage holds its own item.
// Reset: rst_n (synchronous, active low) empties all stages; no other
//   state exists.
// Stall: while out_rsp.ready is low a full stage holds only once every stage
//   after it is full; empty stages keep filling, so in_req.ready drops only
//   once every stage holds an item.
module fixed_point_alu_core import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fpa_req_if.sink   in_req,
  fpa_rsp_if.source out_rsp
);

  localparam int QW = FRAC_BITS + 32;   // quotient magnitude width
  localparam int NS = QW + 3;           // total pipeline stages
  localparam int SP = 1;                // operand stage
  localparam int SL = NS - 1;           // last stage

  typedef struct packed {
    func_e              func;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [63:0] prod;
    logic [31:0]        res;
    logic               cmp;
    logic               dz;
    logic               qneg;
    logic [31:0]        rem;
    logic [QW-1:0]      dvd;
    logic [31:0]        dsor;
  } stage_t;

  logic   [NS-1:0] valid_r;
  stage_t          st_r   [NS];
  stage_t          st_nxt [NS];
  logic   [NS:0]   adv;

  // Advance a stage when it is empty or the one after it advances
  always_comb begin
    adv[NS] = out_rsp.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
  end

  assign in_req.ready = adv[0];

  // Capture the incoming item
  always_comb begin
    st_nxt[0]      = st_r[0];
    st_nxt[0].func = in_req.func;
    st_nxt[0].a    = in_req.operand_a;
    st_nxt[0].b    = in_req.operand_b;
  end

  // Operand stage: simple results, compares, product, divider setup
  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        abs_a;
    logic [31:0]        to_int;
    a = st_r[0].a;
    b = st_r[0].b;
    abs_a = a[31] ? (32'd0 - a) : a;
    to_int = 32'(a >>> FRAC_BITS);
    st_nxt[SP]      = st_r[0];
    st_nxt[SP].prod = a * b;
    st_nxt[SP].res  = '0;
    st_nxt[SP].cmp  = 1'b0;
    st_nxt[SP].dz   = (st_r[0].func == FN_DIV) && (b == 32'sd0);
    st_nxt[SP].qneg = a[31] ^ b[31];
    st_nxt[SP].rem  = '0;
    st_nxt[SP].dvd  = {abs_a, {FRAC_BITS{1'b0}}};
    st_nxt[SP].dsor = b[31] ? (32'd0 - b) : b;
    unique case (st_r[0].func)
      FN_ADD:      st_nxt[SP].res = a + b;
      FN_SUB:      st_nxt[SP].res = a - b;
      FN_GT:       st_nxt[SP].cmp = (a > b);
      FN_LT:       st_nxt[SP].cmp = (a < b);
      FN_GE:       st_nxt[SP].cmp = (a >= b);
      FN_LE:       st_nxt[SP].cmp = (a <= b);
      FN_EQ:       st_nxt[SP].cmp = (a == b);
      FN_NE:       st_nxt[SP].cmp = (a != b);
      FN_MIN:      st_nxt[SP].res = (a < b) ? a : b;
      FN_MAX:      st_nxt[SP].res = (a > b) ? a : b;
      FN_INC:      st_nxt[SP].res = a + 32'sd1;
      FN_DEC:      st_nxt[SP].res = a - 32'sd1;
      FN_FROM_INT: st_nxt[SP].res = a << FRAC_BITS;
      FN_TO_INT:   st_nxt[SP].res = to_int;
      default:     st_nxt[SP].res = '0;
    endcase
  end

  // Divider steps: one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [31:0]   rem_o;
    logic [QW-1:0] dvd_o;

    fpa_div_step #(.QW(QW)) u_step (
      .rem_i  (st_r[SP+k].rem),
      .dvd_i  (st_r[SP+k].dvd),
      .dsor_i (st_r[SP+k].dsor),
      .rem_o  (rem_o),
      .dvd_o  (dvd_o)
    );

    always_comb begin
      st_nxt[SP+1+k]     = st_r[SP+k];
      st_nxt[SP+1+k].rem = rem_o;
      st_nxt[SP+1+k].dvd = dvd_o;
    end
  end

  // Result select: scaled product, signed quotient or simple result
  always_comb begin
    logic signed [63:0] shifted;
    logic [31:0]        quo;
    shifted = st_r[SL-1].prod >>> FRAC_BITS;
    quo     = st_r[SL-1].dvd[31:0];
    st_nxt[SL] = st_r[SL-1];
    if (st_r[SL-1].func == FN_MUL) begin
      st_nxt[SL].res = shifted[31:0];
    end else if (st_r[SL-1].func == FN_DIV) begin
      if (st_r[SL-1].dz) begin
        st_nxt[SL].res = '0;
      end else begin
        st_nxt[SL].res = st_r[SL-1].qneg ? (32'd0 - quo) : quo;
      end
    end
  end

  // Advance valid bits and payload stage by stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (adv[i]) begin
          valid_r[i] <= (i == 0) ? in_req.valid : valid_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (adv[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // Drive the result channel from the last stage
  assign out_rsp.valid          = valid_r[SL];
  assign out_rsp.result         = st_r[SL].res;
  assign out_rsp.compare_true   = st_r[SL].cmp;
  assign out_rsp.divide_by_zero = st_r[SL].dz;

  // A ready receiver never backs up into the request side
  assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.ready |-> in_req.ready)
    else $error("request side stalled while result side ready");

  // A divide by zero reports a zero result
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.divide_by_zero) |-> (out_rsp.result == 32'sd0))
    else $error("divide by zero with nonzero result");

  // A compare reports a zero result
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.compare_true) |-> (out_rsp.result == 32'sd0))
    else $error("compare with nonzero result");

  // Compare and divide flags exclude each other
  assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> !(out_rsp.compare_true && out_rsp.divide_by_zero))
    else $error("compare and divide-by-zero flags both set");

endmodule

// ===== rtl/fpa_div_step.sv =====
// One step of the restoring divider: brings in one dividend bit, makes one
// quotient bit. Depends on fpa_pkg for FRAC_BITS_DEF in the default of QW.
module fpa_div_step import fpa_pkg::*; #(
  parameter int QW = FRAC_BITS_DEF + 32
) (
  input  logic [31:0]   rem_i,
  input  logic [QW-1:0] dvd_i,
  input  logic [31:0]   dsor_i,
  output logic [31:0]   rem_o,
  output logic [QW-1:0] dvd_o
);

  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        qbit;

  // Shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    rem_sh = {rem_i, dvd_i[QW-1]};
    diff   = rem_sh - {1'b0, dsor_i};
    qbit   = (rem_sh >= {1'b0, dsor_i});
    rem_o  = qbit ? diff[31:0] : rem_sh[31:0];
    dvd_o  = {dvd_i[QW-2:0], qbit};
  end

endmodule
